// ===== hdl/dsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector sky pointing package
// Shared widths, constants, the CORDIC arctangent table and common types.
// ----------------------------------------------------------------------------
package dsp_pkg;

	localparam int CORDIC_STAGES_DEF = 32;
	localparam int ATAN_LEN          = 40;

	localparam int IN_W    = 32;        // quaternion component, Q1.30
	localparam int ANG_W   = 34;        // CORDIC angle accumulator
	localparam int TRIG_W  = 34;        // sine, cosine and offset vector, Q30
	localparam int PROD_W  = 66;        // quaternion by offset vector products
	localparam int SUM_W   = 36;        // s, dot and cross terms, Q28
	localparam int R_W     = 72;        // rotated vector before scaling
	localparam int VW      = 68;        // vectoring datapath width

	localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = TRIG_W'(652032874);
	localparam logic [29:0] INV_GAIN_U30 = 30'd652032874;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);
	localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sd2147483648);

	// Configuration register indexes.
	localparam logic [1:0] CFG_OFFSET_X = 2'd0;
	localparam logic [1:0] CFG_OFFSET_Y = 2'd1;
	localparam logic [1:0] CFG_LOCAL    = 2'd2;

	// Sequencer of the offset vector unit.
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ITER,
		ST_MUL,
		ST_IDLE
	} off_state_t;

	// Detector offset vector handed to the rotation pipeline.
	typedef struct packed {
		logic signed [TRIG_W-1:0] vx;
		logic signed [TRIG_W-1:0] vy;
		logic signed [TRIG_W-1:0] vz;
	} offset_vec_t;

	// Arctangent of 2^-i in binary angle units, 2^32 equals 2pi.
	function automatic logic signed [ANG_W-1:0] atan_val(input int idx);
		logic signed [ANG_W-1:0] r;
		unique case (idx)
			0:  r = ANG_W'(32'h20000000);
			1:  r = ANG_W'(32'h12E4051E);
			2:  r = ANG_W'(32'h09FB385B);
			3:  r = ANG_W'(32'h051111D4);
			4:  r = ANG_W'(32'h028B0D43);
			5:  r = ANG_W'(32'h0145D7E1);
			6:  r = ANG_W'(32'h00A2F61E);
			7:  r = ANG_W'(32'h00517C55);
			8:  r = ANG_W'(32'h0028BE53);
			9:  r = ANG_W'(32'h00145F2F);
			10: r = ANG_W'(32'h000A2F98);
			11: r = ANG_W'(32'h000517CC);
			12: r = ANG_W'(32'h00028BE6);
			13: r = ANG_W'(32'h000145F3);
			14: r = ANG_W'(32'h0000A2FA);
			15: r = ANG_W'(32'h0000517D);
			16: r = ANG_W'(32'h000028BE);
			17: r = ANG_W'(32'h0000145F);
			18: r = ANG_W'(32'h00000A30);
			19: r = ANG_W'(32'h00000518);
			20: r = ANG_W'(32'h0000028C);
			21: r = ANG_W'(32'h00000146);
			22: r = ANG_W'(32'h000000A3);
			23: r = ANG_W'(32'h00000051);
			24: r = ANG_W'(32'h00000029);
			25: r = ANG_W'(32'h00000014);
			26: r = ANG_W'(32'h0000000A);
			27: r = ANG_W'(32'h00000005);
			28: r = ANG_W'(32'h00000003);
			29: r = ANG_W'(32'h00000001);
			30: r = ANG_W'(32'h00000001);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/dsp_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector offset vector unit
// Iterative CORDIC that turns the two offset angles into the offset vector.
// ----------------------------------------------------------------------------
module dsp_offset #(
	parameter int STAGES = dsp_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic signed [dsp_pkg::IN_W-1:0]     ang_x,
	input  logic signed [dsp_pkg::IN_W-1:0]     ang_y,
	output logic                                busy,
	output dsp_pkg::offset_vec_t                vec
);
	import dsp_pkg::*;

	localparam int N  = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;
	localparam int IW = $clog2(N);

	off_state_t state_q, state_nxt;
	logic [IW-1:0] cnt_q;
	logic signed [TRIG_W-1:0] x_q [2];
	logic signed [TRIG_W-1:0] y_q [2];
	logic signed [ANG_W-1:0]  z_q [2];
	logic                     neg_q [2];
	logic signed [IN_W-1:0]   ang [2];
	logic signed [TRIG_W-1:0] c [2];
	logic signed [TRIG_W-1:0] s [2];
	logic signed [2*TRIG_W-1:0] pxx, pxy;
	offset_vec_t vec_q;

	assign ang[0] = ang_x;
	assign ang[1] = ang_y;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: state_nxt = ST_ITER;
			ST_ITER: state_nxt = (cnt_q == IW'(N-1)) ? ST_MUL : ST_ITER;
			ST_MUL:  state_nxt = ST_IDLE;
			ST_IDLE: state_nxt = ST_IDLE;
			default: state_nxt = ST_LOAD;
		endcase
		if (restart) begin
			state_nxt = ST_LOAD;
		end
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Lane 0 works on the x angle, lane 1 on the y angle.
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (state_q == ST_LOAD) begin
				logic signed [ANG_W-1:0] z0;
				z0 = ANG_W'(ang[l]);
				neg_q[l] <= (z0 > QUARTER_TURN) || (z0 < -QUARTER_TURN);
				if (z0 > QUARTER_TURN) begin
					z_q[l] <= z0 - HALF_TURN;
				end else if (z0 < -QUARTER_TURN) begin
					z_q[l] <= z0 + HALF_TURN;
				end else begin
					z_q[l] <= z0;
				end
				x_q[l] <= INV_GAIN_Q30;
				y_q[l] <= '0;
			end else if (state_q == ST_ITER) begin
				if (!z_q[l][ANG_W-1]) begin
					x_q[l] <= x_q[l] - (y_q[l] >>> cnt_q);
					y_q[l] <= y_q[l] + (x_q[l] >>> cnt_q);
					z_q[l] <= z_q[l] - atan_val(int'(cnt_q));
				end else begin
					x_q[l] <= x_q[l] + (y_q[l] >>> cnt_q);
					y_q[l] <= y_q[l] - (x_q[l] >>> cnt_q);
					z_q[l] <= z_q[l] + atan_val(int'(cnt_q));
				end
			end
		end
		if (state_q == ST_LOAD) begin
			cnt_q <= '0;
		end else if (state_q == ST_ITER) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			c[l] = neg_q[l] ? -x_q[l] : x_q[l];
			s[l] = neg_q[l] ? -y_q[l] : y_q[l];
		end
		pxx = (2*TRIG_W)'(c[1]) * (2*TRIG_W)'(c[0]);
		pxy = (2*TRIG_W)'(c[1]) * (2*TRIG_W)'(s[0]);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			vec_q.vx <= pxx[30+TRIG_W-1:30];
			vec_q.vy <= pxy[30+TRIG_W-1:30];
			vec_q.vz <= -s[1];
		end
	end

	assign vec = vec_q;

endmodule

// ===== hdl/dsp_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion rotation pipeline
// Four stages that form q v q* for the fixed offset vector v.
// ----------------------------------------------------------------------------
module dsp_rotate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [dsp_pkg::IN_W-1:0]   in_w,
	input  logic signed [dsp_pkg::IN_W-1:0]   in_x,
	input  logic signed [dsp_pkg::IN_W-1:0]   in_y,
	input  logic signed [dsp_pkg::IN_W-1:0]   in_z,
	input  logic                              in_last,
	input  dsp_pkg::offset_vec_t              vec,
	output logic                              out_valid,
	output logic signed [dsp_pkg::VW-1:0]     out_px,
	output logic signed [dsp_pkg::VW-1:0]     out_py,
	output logic signed [dsp_pkg::VW-1:0]     out_pz,
	output logic                              out_last
);
	import dsp_pkg::*;

	localparam int DW = PROD_W + 2;

	logic val_s1, val_s2, val_s3, val_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [IN_W-1:0] w_s1, x_s1, y_s1, z_s1, w_s2, x_s2, y_s2, z_s2;
	logic signed [PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PROD_W-1:0] xvx_s1, yvy_s1, zvz_s1;
	logic signed [PROD_W-1:0] yvz_s1, zvy_s1, zvx_s1, xvz_s1, xvy_s1, yvx_s1;
	logic signed [SUM_W-1:0] s_s2, dot_s2, crx_s2, cry_s2, crz_s2;
	logic signed [R_W-1:0] svx_s3, svy_s3, svz_s3, dx_s3, dy_s3, dz_s3;
	logic signed [R_W-1:0] cx_s3, cy_s3, cz_s3;
	logic signed [VW-1:0] px_s4, py_s4, pz_s4;
	logic signed [DW-1:0] dot_sum, crx_sum, cry_sum, crz_sum;
	logic signed [R_W-1:0] rx, ry, rz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
		end else if (en) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
		end
	end

	// Stage 1: squares and component products.
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1  <= PROD_W'(in_w) * PROD_W'(in_w);
			xx_s1  <= PROD_W'(in_x) * PROD_W'(in_x);
			yy_s1  <= PROD_W'(in_y) * PROD_W'(in_y);
			zz_s1  <= PROD_W'(in_z) * PROD_W'(in_z);
			xvx_s1 <= PROD_W'(in_x) * PROD_W'(vec.vx);
			yvy_s1 <= PROD_W'(in_y) * PROD_W'(vec.vy);
			zvz_s1 <= PROD_W'(in_z) * PROD_W'(vec.vz);
			yvz_s1 <= PROD_W'(in_y) * PROD_W'(vec.vz);
			zvy_s1 <= PROD_W'(in_z) * PROD_W'(vec.vy);
			zvx_s1 <= PROD_W'(in_z) * PROD_W'(vec.vx);
			xvz_s1 <= PROD_W'(in_x) * PROD_W'(vec.vz);
			xvy_s1 <= PROD_W'(in_x) * PROD_W'(vec.vy);
			yvx_s1 <= PROD_W'(in_y) * PROD_W'(vec.vx);
			w_s1 <= in_w;
			x_s1 <= in_x;
			y_s1 <= in_y;
			z_s1 <= in_z;
			last_s1 <= in_last;
		end
	end

	// Stage 2: scalar term, dot and cross products, all Q28.
	always_comb begin
		dot_sum = DW'(xvx_s1) + DW'(yvy_s1) + DW'(zvz_s1);
		crx_sum = DW'(yvz_s1) - DW'(zvy_s1);
		cry_sum = DW'(zvx_s1) - DW'(xvz_s1);
		crz_sum = DW'(xvy_s1) - DW'(yvx_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= SUM_W'(ww_s1[PROD_W-1:32]) - SUM_W'(xx_s1[PROD_W-1:32])
				- SUM_W'(yy_s1[PROD_W-1:32]) - SUM_W'(zz_s1[PROD_W-1:32]);
			dot_s2 <= dot_sum[DW-1:32];
			crx_s2 <= crx_sum[DW-1:32];
			cry_s2 <= cry_sum[DW-1:32];
			crz_s2 <= crz_sum[DW-1:32];
			w_s2 <= w_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: the three products of each rotated component.
	always_ff @(posedge clk) begin
		if (en) begin
			svx_s3 <= R_W'(s_s2) * R_W'(vec.vx);
			svy_s3 <= R_W'(s_s2) * R_W'(vec.vy);
			svz_s3 <= R_W'(s_s2) * R_W'(vec.vz);
			dx_s3  <= R_W'(dot_s2) * R_W'(x_s2);
			dy_s3  <= R_W'(dot_s2) * R_W'(y_s2);
			dz_s3  <= R_W'(dot_s2) * R_W'(z_s2);
			cx_s3  <= R_W'(w_s2) * R_W'(crx_s2);
			cy_s3  <= R_W'(w_s2) * R_W'(cry_s2);
			cz_s3  <= R_W'(w_s2) * R_W'(crz_s2);
			last_s3 <= last_s2;
		end
	end

	// Stage 4: sum in Q57 and drop four bits for the vectoring units.
	always_comb begin
		rx = (svx_s3 >>> 1) + dx_s3 + cx_s3;
		ry = (svy_s3 >>> 1) + dy_s3 + cy_s3;
		rz = (svz_s3 >>> 1) + dz_s3 + cz_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s4 <= rx[R_W-1:4];
			py_s4 <= ry[R_W-1:4];
			pz_s4 <= rz[R_W-1:4];
			last_s4 <= last_s3;
		end
	end

	assign out_valid = val_s4;
	assign out_px    = px_s4;
	assign out_py    = py_s4;
	assign out_pz    = pz_s4;
	assign out_last  = last_s4;

endmodule

// ===== hdl/dsp_vector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring CORDIC pipeline
// One register stage per iteration; gives angle and gain-scaled magnitude.
// ----------------------------------------------------------------------------
module dsp_vector #(
	parameter int STAGES = dsp_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic signed [dsp_pkg::VW-1:0]      in_x,
	input  logic signed [dsp_pkg::VW-1:0]      in_y,
	input  logic [SIDE_W-1:0]                  in_side,
	output logic                               out_valid,
	output logic signed [dsp_pkg::ANG_W-1:0]   out_ang,
	output logic signed [dsp_pkg::VW-1:0]      out_mag,
	output logic [SIDE_W-1:0]                  out_side
);
	import dsp_pkg::*;

	localparam int N = (STAGES < ATAN_LEN) ? STAGES : ATAN_LEN;

	logic                    val_s  [0:N];
	logic signed [VW-1:0]    x_s    [0:N];
	logic signed [VW-1:0]    y_s    [0:N];
	logic signed [ANG_W-1:0] a_s    [0:N];
	logic [SIDE_W-1:0]       side_s [0:N];

	assign val_s[0]  = in_valid;
	assign x_s[0]    = in_x;
	assign y_s[0]    = in_y;
	assign a_s[0]    = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_s[i+1] <= 1'b0;
			end else if (en) begin
				val_s[i+1] <= val_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][VW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_val(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_val(i);
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = val_s[N];
	assign out_ang   = a_s[N];
	assign out_mag   = x_s[N];
	assign out_side  = side_s[N];

endmodule

// ===== hdl/detector_sky_pointing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector sky pointing
// Rotates a fixed detector offset by each boresight quaternion and returns
// longitude and latitude as binary angles.
// ----------------------------------------------------------------------------
// One transfer in, one transfer out, in order. The pipeline accepts a new
// quaternion in every cycle unless the output stalls or the offset vector is
// being rebuilt. It holds four rotation stages, one fold stage, two vectoring
// CORDIC pipelines of CORDIC_STAGES stages each (at most ATAN_LEN), two
// gain-removal stages and the output register. A stalled output holds the
// whole pipeline, so nothing is lost. After reset and after every
// configuration write the offset vector is rebuilt by an iterative CORDIC;
// s_axis_tready stays low during that time. Offset angles are binary angles
// with 2^31 equal to pi; the longitude is unsigned with 2^32 equal to 2pi and
// the latitude signed in [-2^30, 2^30], negated when local_frame is set.
// ----------------------------------------------------------------------------
module detector_sky_pointing #(
	parameter int CORDIC_STAGES = dsp_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// Input quaternion stream.
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [127:0]  s_axis_tdata,   // rot_w, rot_x, rot_y, rot_z (32 bits each)
	input  logic          s_axis_tlast,   // last_sample
	// Output pointing stream.
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [63:0]   m_axis_tdata,   // longitude, latitude (32 bits each)
	output logic          m_axis_tlast,   // last_out
	// Configuration write port.
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import dsp_pkg::*;

	localparam int SIDE1_W = VW + 3;
	localparam int SIDE2_W = 34;

	logic signed [IN_W-1:0] off_x_q, off_y_q;
	logic                   local_q;
	logic                   busy;
	offset_vec_t            vec;
	logic                   en, accept;

	logic                   rot_valid, rot_last;
	logic signed [VW-1:0]   rot_px, rot_py, rot_pz;

	logic                   val_s5, hzero_s5, base_s5, last_s5;
	logic signed [VW-1:0]   x_s5, y_s5, pz_s5;

	logic                   v1_valid;
	logic signed [ANG_W-1:0] v1_ang;
	logic signed [VW-1:0]   v1_mag;
	logic [SIDE1_W-1:0]     v1_side;
	logic                   v1_last, v1_base, v1_hzero;
	logic signed [VW-1:0]   v1_pz, mag_eff;

	logic                   val_s6, last_s6, val_s7, last_s7;
	logic [VW-1:0]          hi_s6;
	logic [59:0]            lo_s6;
	logic [31:0]            lon_s6, lon_s7;
	logic signed [VW-1:0]   pz_s6, hc_s7, pz_s7;
	logic                   latz;

	logic                   v2_valid;
	logic signed [ANG_W-1:0] v2_ang;
	logic signed [VW-1:0]   v2_mag;
	logic [SIDE2_W-1:0]     v2_side;
	logic signed [ANG_W-1:0] lat_c;

	logic                   val_s8, last_s8;
	logic [31:0]            lon_s8, lat_s8;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			local_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_X: off_x_q <= cfg_data;
				CFG_OFFSET_Y: off_y_q <= cfg_data;
				CFG_LOCAL:    local_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dsp_offset #(.STAGES(CORDIC_STAGES)) u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.ang_x   (off_x_q),
		.ang_y   (off_y_q),
		.busy    (busy),
		.vec     (vec)
	);

	// The whole pipeline moves unless the output register holds an untaken result.
	assign en            = !val_s8 || m_axis_tready;
	assign s_axis_tready = en && !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	dsp_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (accept),
		.in_w      (s_axis_tdata[31:0]),
		.in_x      (s_axis_tdata[63:32]),
		.in_y      (s_axis_tdata[95:64]),
		.in_z      (s_axis_tdata[127:96]),
		.in_last   (s_axis_tlast),
		.vec       (vec),
		.out_valid (rot_valid),
		.out_px    (rot_px),
		.out_py    (rot_py),
		.out_pz    (rot_pz),
		.out_last  (rot_last)
	);

	// Fold stage: a vector with negative x is turned by pi so that vectoring
	// starts in the right half plane. A vector with no horizontal part is
	// flagged, since its longitude is defined as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s5 <= 1'b0;
		end else if (en) begin
			val_s5 <= rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hzero_s5 <= (rot_px == '0) && (rot_py == '0);
			base_s5  <= rot_px[VW-1];
			x_s5     <= rot_px[VW-1] ? -rot_px : rot_px;
			y_s5     <= rot_px[VW-1] ? -rot_py : rot_py;
			pz_s5    <= rot_pz;
			last_s5  <= rot_last;
		end
	end

	dsp_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE1_W)) u_vec_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (val_s5),
		.in_x      (x_s5),
		.in_y      (y_s5),
		.in_side   ({last_s5, base_s5, hzero_s5, pz_s5}),
		.out_valid (v1_valid),
		.out_ang   (v1_ang),
		.out_mag   (v1_mag),
		.out_side  (v1_side)
	);

	assign {v1_last, v1_base, v1_hzero, v1_pz} = v1_side;
	assign mag_eff = v1_hzero ? '0 : v1_mag;

	// Gain removal, first half: the magnitude is split at bit 30 so that each
	// product with the inverse gain stays within a normal multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s6 <= 1'b0;
			val_s7 <= 1'b0;
		end else if (en) begin
			val_s6 <= v1_valid;
			val_s7 <= val_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s6   <= VW'(mag_eff[VW-1:30]) * VW'(INV_GAIN_U30);
			lo_s6   <= 60'(mag_eff[29:0]) * 60'(INV_GAIN_U30);
			lon_s6  <= v1_hzero ? 32'd0 : (v1_ang[31:0] + {v1_base, 31'd0});
			pz_s6   <= v1_pz;
			last_s6 <= v1_last;
		end
	end

	// Gain removal, second half.
	always_ff @(posedge clk) begin
		if (en) begin
			hc_s7   <= $signed(hi_s6 + VW'(lo_s6[59:30]));
			pz_s7   <= pz_s6;
			lon_s7  <= lon_s6;
			last_s7 <= last_s6;
		end
	end

	// A zero vector has latitude zero.
	assign latz = (hc_s7 == '0) && (pz_s7 == '0);

	dsp_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE2_W)) u_vec_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (val_s7),
		.in_x      (hc_s7),
		.in_y      (pz_s7),
		.in_side   ({last_s7, latz, lon_s7}),
		.out_valid (v2_valid),
		.out_ang   (v2_ang),
		.out_mag   (v2_mag),
		.out_side  (v2_side)
	);

	// Zero or clamped latitude (a quarter turn either way), then the local-frame sign.
	always_comb begin
		if (v2_side[32]) begin
			lat_c = '0;
		end else if (v2_ang > QUARTER_TURN) begin
			lat_c = QUARTER_TURN;
		end else if (v2_ang < -QUARTER_TURN) begin
			lat_c = -QUARTER_TURN;
		end else begin
			lat_c = v2_ang;
		end
		if (local_q) begin
			lat_c = -lat_c;
		end
	end

	// Output register. The magnitude of the latitude vectoring is not needed,
	// only its sign bit is kept as a sanity term that never changes the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s8 <= 1'b0;
		end else if (en) begin
			val_s8 <= v2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lon_s8  <= v2_side[31:0];
			lat_s8  <= lat_c[31:0] & {32{!(v2_mag[VW-1] & 1'b0)}};
			last_s8 <= v2_side[33];
		end
	end

	assign m_axis_tvalid = val_s8;
	assign m_axis_tdata  = {lat_s8, lon_s8};
	assign m_axis_tlast  = last_s8;

endmodule

// ===== tb/tb_detector_sky_pointing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector sky pointing testbench
// Streams boresight quaternions through the block under several detector
// offsets and frame settings, with random gaps and stalls on both streams.
// Every result is checked against a bit-exact integer CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_detector_sky_pointing;

	import dsp_pkg::*;

	localparam int STAGES    = 32;
	localparam int LATENCY   = 2 * STAGES + 8;
	localparam int WDOG_MAX  = 5000;
	localparam int HOLD_LEN  = 400;
	localparam int PHASE_LEN = 310;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [31:0] w;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} quat_t;

	typedef struct {
		logic [31:0] lon;
		logic [31:0] lat;
		logic        last;
	} pointing_t;

	// Arctangent of 2^-i in binary angle units; later entries are zero.
	localparam logic [31:0] ATAN_TAB [0:30] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001
	};

	localparam wide_t K_GAIN = 652032874;
	localparam wide_t QTURN  = 128'sd1073741824;
	localparam wide_t HTURN  = 128'sd2147483648;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;    // rot_w, rot_x, rot_y, rot_z (32 bits each)
	logic         s_axis_tlast;    // last_sample
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;    // longitude, latitude (32 bits each)
	logic         m_axis_tlast;    // last_out
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	detector_sky_pointing u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow copy of the configuration registers, updated as each write is issued.
	logic [31:0] sh_off_x;
	logic [31:0] sh_off_y;
	logic        sh_local;

	quat_t     quat_q[$];        // quaternions waiting to be offered
	pointing_t pointing_q[$];    // predicted pointing, oldest first
	quat_t     cur_quat;
	int        err_cnt;
	int        send_gap;
	int        recv_gap;
	int        hold_cnt;
	int        hold_req;         // bumped by the stimulus to ask for a long stall
	int        hold_seen;
	int        quiet_cycles;
	bit        no_idle;          // stretches with no gaps on either side

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// --------------------------------------------------------------------------
	// Predictor
	// --------------------------------------------------------------------------

	// Rotation CORDIC: cosine and sine in Q30 of a binary angle (2^31 is pi).
	function automatic void offset_trig(input wide_t ang, output wide_t c, output wide_t s);
		wide_t x, y, z, dx, dy;
		bit    fold;
		x    = K_GAIN;
		y    = 0;
		z    = ang;
		fold = 1'b0;
		if (z > QTURN || z < -QTURN) begin
			z    = (z > 0) ? z - HTURN : z + HTURN;
			fold = 1'b1;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - wide_t'(ATAN_TAB[i > 30 ? 30 : i]) * (i <= 30);
			end else begin
				x = x + dx; y = y - dy; z = z + wide_t'(ATAN_TAB[i > 30 ? 30 : i]) * (i <= 30);
			end
		end
		c = fold ? -x : x;
		s = fold ? -y : y;
	endfunction

	// Vectoring CORDIC for x >= 0: accumulated angle and magnitude with gain.
	function automatic void vector_angle(input wide_t x0, input wide_t y0,
	                                     output wide_t ang, output wide_t mag);
		wide_t x, y, a, dx, dy, step;
		x = x0;
		y = y0;
		a = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx   = y >>> i;
			dy   = x >>> i;
			step = (i <= 30) ? wide_t'(ATAN_TAB[i > 30 ? 30 : i]) : 0;
			if (y >= 0) begin
				x = x + dx; y = y - dy; a = a + step;
			end else begin
				x = x - dx; y = y + dy; a = a - step;
			end
		end
		ang = a;
		mag = x;
	endfunction

	function automatic pointing_t predict_pointing(quat_t q);
		wide_t cx, sx, cy, sy, vx, vy, vz, w, ux, uy, uz;
		wide_t s, dot, crx, cry, crz, rx, ry, rz, px, py, pz;
		wide_t ang, mag, hc, lat, base;
		pointing_t r;
		offset_trig(wide_t'($signed(sh_off_x)), cx, sx);
		offset_trig(wide_t'($signed(sh_off_y)), cy, sy);
		vx = (cy * cx) >>> 30;
		vy = (cy * sx) >>> 30;
		vz = -sy;
		w  = q.w;
		ux = q.x;
		uy = q.y;
		uz = q.z;
		s   = ((w * w) >>> 32) - ((ux * ux) >>> 32) - ((uy * uy) >>> 32) - ((uz * uz) >>> 32);
		dot = (ux * vx + uy * vy + uz * vz) >>> 32;
		crx = (uy * vz - uz * vy) >>> 32;
		cry = (uz * vx - ux * vz) >>> 32;
		crz = (ux * vy - uy * vx) >>> 32;
		rx  = ((s * vx) >>> 1) + dot * ux + w * crx;
		ry  = ((s * vy) >>> 1) + dot * uy + w * cry;
		rz  = ((s * vz) >>> 1) + dot * uz + w * crz;
		px  = rx >>> 4;
		py  = ry >>> 4;
		pz  = rz >>> 4;
		// A vector along the pole has no longitude; it is reported as zero.
		if (px == 0 && py == 0) begin
			r.lon = '0;
			mag   = 0;
		end else begin
			base = 0;
			// Negative horizontal x: turn by pi so the CORDIC converges.
			if (px < 0) begin
				px   = -px;
				py   = -py;
				base = HTURN;
			end
			vector_angle(px, py, ang, mag);
			r.lon = 32'(base + ang);
		end
		hc = ((mag >>> 30) * K_GAIN) + (((mag & (QTURN - 1)) * K_GAIN) >>> 30);
		if (hc == 0 && pz == 0) begin
			lat = 0;
		end else begin
			vector_angle(hc, pz, lat, mag);
			if (lat > QTURN) lat = QTURN;
			if (lat < -QTURN) lat = -QTURN;
		end
		if (sh_local) lat = -lat;
		r.lat  = 32'(lat);
		r.last = q.last;
		return r;
	endfunction

	// --------------------------------------------------------------------------
	// Sender side: offers queued quaternions with random gaps.
	// --------------------------------------------------------------------------

	function automatic int draw_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			send_gap      = 0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			// The previous offer, if any, was taken at this edge.
			if (s_axis_tvalid)
				pointing_q.push_back(predict_pointing(cur_quat));
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (quat_q.size() > 0) begin
				cur_quat = quat_q.pop_front();
				s_axis_tdata  <= {cur_quat.z, cur_quat.y, cur_quat.x, cur_quat.w};
				s_axis_tlast  <= cur_quat.last;
				s_axis_tvalid <= 1'b1;
				send_gap = draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------------
	// Receiver side: random back-pressure and comparison of each transfer.
	// --------------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pointing_t exp_pnt;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap  = 0;
			hold_cnt  = 0;
			hold_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pointing_q.size() == 0) begin
					$display("%0t: unexpected pointing transfer %h", $realtime, m_axis_tdata);
					err_cnt++;
				end else begin
					exp_pnt = pointing_q.pop_front();
					if (m_axis_tdata[31:0] !== exp_pnt.lon)
						report_mismatch("longitude", m_axis_tdata[31:0], exp_pnt.lon);
					if (m_axis_tdata[63:32] !== exp_pnt.lat)
						report_mismatch("latitude", m_axis_tdata[63:32], exp_pnt.lat);
					if (m_axis_tlast !== exp_pnt.last)
						report_mismatch("last", 32'(m_axis_tlast), 32'(exp_pnt.last));
				end
			end
			// A long stall fills the pipeline so that the input side backs up.
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_cnt  = HOLD_LEN;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap = draw_gap();
			end
		end
	end

	// Watchdog: ends the run if neither stream moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_MAX) begin
			$display("** detector_sky_pointing: FAILED **");
			$finish;
		end
	end

	// --------------------------------------------------------------------------
	// Stimulus
	// --------------------------------------------------------------------------

	task automatic add_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
	                        logic last);
		quat_t q;
		q.w = w; q.x = x; q.y = y; q.z = z; q.last = last;
		quat_q.push_back(q);
	endtask

	// Waits until every offered quaternion has come back as a pointing transfer.
	task automatic wait_drained();
		while (quat_q.size() > 0 || s_axis_tvalid || pointing_q.size() > 0)
			@(posedge clk);
	endtask

	// Only legal while the block is drained; the shadow follows the write.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_OFFSET_X: sh_off_x = val;
			CFG_OFFSET_Y: sh_off_y = val;
			CFG_LOCAL:    sh_local = val[0];
			default:      ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] loc);
		write_reg(CFG_OFFSET_X, ox);
		write_reg(CFG_OFFSET_Y, oy);
		write_reg(CFG_LOCAL, loc);
	endtask

	// Mostly well-scaled quaternions of random orientation, some at full
	// range, and a few with zeroed components to reach the poles.
	task automatic add_random(int n);
		logic [31:0] c [4];
		int kind;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(0, 99);
			foreach (c[j]) c[j] = $urandom;
			if (kind < 60) begin
				foreach (c[j]) c[j] = $signed(c[j]) >>> 2;
			end else if (kind < 85) begin
				// full range, every bit free
			end else begin
				foreach (c[j]) if ($urandom_range(0, 1)) c[j] = '0;
			end
			add_quat(c[0], c[1], c[2], c[3], $urandom_range(0, 15) == 0);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_OFFSET_X;
		cfg_data  = '0;
		sh_off_x  = '0;
		sh_off_y  = '0;
		sh_local  = 1'b0;
		err_cnt   = 0;
		hold_req  = 0;
		no_idle   = 1'b0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset configuration.
		add_quat(32'h40000000, 0, 0, 0, 1'b0);                 // identity
		add_quat(0, 0, 0, 0, 1'b1);                            // zero quaternion
		add_quat(0, 0, 0, 32'h40000000, 1'b0);                 // half turn about z
		add_quat(0, 0, 32'h40000000, 0, 1'b0);                 // half turn about y
		add_quat(32'h2D413CCD, 0, 32'h2D413CCD, 0, 1'b1);      // towards a pole
		add_quat(32'h2D413CCD, 0, 32'hD2BEC333, 0, 1'b0);      // the other pole
		add_quat(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		add_quat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
		add_quat(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b0);
		add_quat(32'h00000001, 32'hFFFFFFFF, 0, 0, 1'b0);      // tiny, not unit
		add_quat(32'h2D413CCD, 0, 0, 32'h2D413CCD, 1'b0);      // quarter turn about z
		add_quat(32'h2D413CCD, 0, 0, 32'hD2BEC333, 1'b1);
		wait_drained();

		// A ignored index, then a wide value of which only bit 0 reaches local_frame.
		write_reg(2'd3, 32'hFFFFFFFF);
		configure(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFE);
		add_quat(32'h40000000, 0, 0, 0, 1'b0);
		add_quat(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1);
		add_quat(0, 32'h40000000, 0, 0, 1'b0);
		wait_drained();

		// Fold boundaries of the offset angles, local frame on.
		configure(32'h40000000, 32'hC0000000, 32'h1);
		add_quat(32'h40000000, 0, 0, 0, 1'b1);
		add_quat(32'h2D413CCD, 32'h2D413CCD, 0, 0, 1'b0);
		add_random(PHASE_LEN);
		// Hold the output off while the sender keeps offering.
		@(posedge clk);
		hold_req <= hold_req + 1;
		wait_drained();

		configure(32'h40000001, 32'hBFFFFFFF, 32'h0);
		no_idle = 1'b1;
		add_random(PHASE_LEN);
		wait_drained();
		no_idle = 1'b0;

		configure(32'h80000000, 32'h7FFFFFFF, 32'h1);
		add_random(PHASE_LEN);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			configure($urandom, $urandom, $urandom);
			add_random(PHASE_LEN);
			if (p == 1) begin
				@(posedge clk);
				hold_req <= hold_req + 1;
			end
			wait_drained();
		end

		repeat (LATENCY + 8) @(posedge clk);
		if (err_cnt == 0)
			$display("** detector_sky_pointing: PASSED **");
		else
			$display("** detector_sky_pointing: FAILED **");
		$finish;
	end

endmodule
